[src/bmi_pkg.sv]
// Package for the binary modular inverse block.
// Holds operand and coefficient widths and the sequencer state type.
// No dependencies.
`default_nettype none

package bmi_pkg;

   // Width of the value, the modulus and the inverse
   localparam int VALUE_BITS = 31;
   // Signed coefficient width: holds sums up to twice the modulus with sign
   localparam int COEF_BITS = VALUE_BITS + 2;

   typedef logic [VALUE_BITS-1:0]       value_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_STRIP = 7'b0000010,
      ST_LOOP  = 7'b0000100,
      ST_FIX   = 7'b0001000,
      ST_FINLO = 7'b0010000,
      ST_FINHI = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

[src/binary_modular_inverse.sv]
// Binary modular inverse: top level with sequencer and shared datapath.
// Depends on bmi_pkg (widths, state type).
//
// Usage: an item (req_value, req_modulus) is accepted when req_valid is high
// and req_stall is low. req_stall stays high from acceptance until the result
// is placed in the output register, so one item is worked on at a time.
// The result item (rsp_inverse_out, rsp_no_inverse) is shown with rsp_valid
// and is taken at an edge where rsp_stall is low; while stalled it holds.
// A new item may be accepted while the previous result still waits.
// rsp_no_inverse is set, with inverse 0, for a zero or even modulus, a zero
// value, or a gcd other than one.
// Each step of the binary extended Euclidean loop runs on one shared 31-bit
// subtract/compare unit and one 33-bit coefficient adder. Factors of two are
// stripped from the value one zero bit at a time; the loop then halves, swaps
// or subtracts, each subtraction followed by a bound fix-up, and entry, final
// reduction and output steps close the item. There are fewer than 62
// halvings in all, and each one on the modulus side follows at most one swap
// and one subtraction. Special cases go from acceptance straight to the done
// state and then to the output register. Reset (synchronous) returns to idle
// and drops rsp_valid.
`default_nettype none

module binary_modular_inverse
   import bmi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [VALUE_BITS-1:0] req_modulus,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_BITS-1:0]      rsp_inverse_out,
   output logic                       rsp_no_inverse
);

   state_type state_ff, state_in;
   value_type a_ff, a_in;
   value_type b_ff, b_in;
   value_type m_ff, m_in;
   coef_type  u_ff, u_in;
   coef_type  s_ff, s_in;
   logic      err_ff, err_in;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_inv_ff, rsp_inv_in;
   logic      rsp_err_ff, rsp_err_in;

   logic               accept;
   logic               load_out;
   logic [VALUE_BITS:0] diff;
   logic               b_lt_a;
   logic               a_eq_b;
   coef_type           m_ext;
   coef_type           neg_m;
   coef_type           op1, op2;
   logic               op_sub;
   coef_type           coef_sum;
   coef_type           half_src;
   coef_type           coef_half;
   logic               u_pos;

   assign accept   = req_valid && !req_stall;
   assign load_out = !rsp_valid_ff || !rsp_stall;

   // Shared operand unit: b - a gives both the compare and the subtraction
   assign diff   = {1'b0, b_ff} - {1'b0, a_ff};
   assign b_lt_a = diff[VALUE_BITS];
   assign a_eq_b = (diff == '0);

   assign m_ext = coef_type'({2'b00, m_ff});
   assign neg_m = -m_ext;
   assign u_pos = (u_ff > 0);

   // Operand select for the shared coefficient adder
   always_comb begin
      op1    = s_ff;
      op2    = m_ext;
      op_sub = 1'b0;
      unique case (state_ff)
         ST_STRIP: begin
            op1 = u_ff;
         end
         ST_LOOP: begin
            if (b_ff[0] && !b_lt_a) begin
               op2    = u_ff;
               op_sub = 1'b1;
            end
         end
         ST_FIX: begin
            op_sub = !u_pos;
         end
         ST_FINHI: begin
            op_sub = 1'b1;
         end
         default: begin
            op_sub = 1'b0;
         end
      endcase
   end

   assign coef_sum = op1 + (op_sub ? ~op2 : op2) + coef_type'(op_sub);

   // Exact halving: add the modulus first when the coefficient is odd
   assign half_src  = op1[0] ? coef_sum : op1;
   assign coef_half = half_src >>> 1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      m_in         = m_ff;
      u_in         = u_ff;
      s_in         = s_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_inv_in   = rsp_inv_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in = req_value;
               b_in = req_modulus;
               m_in = req_modulus;
               u_in = coef_type'(1);
               s_in = '0;
               if (req_modulus == '0 || !req_modulus[0] || req_value == '0) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (!a_ff[0]) begin
               a_in = a_ff >> 1;
               u_in = coef_half;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            priority if (a_eq_b) begin
               if (a_ff != value_type'(1)) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FINLO;
               end
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
               s_in = coef_half;
            end else if (b_lt_a) begin
               a_in = b_ff;
               b_in = a_ff;
               u_in = s_ff;
               s_in = u_ff;
            end else begin
               b_in     = diff[VALUE_BITS-1:0];
               s_in     = coef_sum;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // keep s inside the open interval (-m, m)
            if (u_pos) begin
               if (s_ff <= neg_m) s_in = coef_sum;
            end else begin
               if (s_ff >= m_ext) s_in = coef_sum;
            end
            state_in = ST_LOOP;
         end
         ST_FINLO: begin
            if (s_ff < 0) s_in = coef_sum;
            state_in = ST_FINHI;
         end
         ST_FINHI: begin
            if (s_ff >= m_ext) s_in = coef_sum;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_inv_in   = err_ff ? '0 : s_ff[VALUE_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      m_ff       <= m_in;
      u_ff       <= u_in;
      s_ff       <= s_in;
      rsp_inv_ff <= rsp_inv_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inverse_out = rsp_inv_ff;
   assign rsp_no_inverse  = rsp_err_ff;

   // The working value stays odd and nonzero once the main loop is entered
   a_odd_in_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (a_ff[0] && b_ff != '0))
      else $error("working value lost oddness or modulus side hit zero");

   // A flagged result always carries a zero inverse
   err_zero_inv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_inv_ff == '0))
      else $error("no-inverse result with nonzero inverse");

   // An accepted item starts either the strip phase or a flagged result
   accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_STRIP || (state_ff == ST_DONE && err_ff)))
      else $error("bad sequencer entry after accept");

   // A good result is fully reduced below the modulus
   inv_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !err_ff) |-> (s_ff >= 0 && s_ff < m_ext))
      else $error("final coefficient out of range");

endmodule

`default_nettype wire
